/* rtl/tll_pkg.sv */
package tll_pkg;

   // Geometry of the buffer
   localparam int ENTRIES   = 16;
   localparam int PAGE_BITS = 20;
   localparam int SLOT_W    = $clog2(ENTRIES);
   localparam int RANK_W    = SLOT_W;
   localparam int COUNT_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W     = 5;
   localparam int PERM_W    = 3;
   localparam int DATA_W    = PAGE_BITS + PERM_W;
   localparam int CAP_RESET = 16;

   typedef logic [PAGE_BITS-1:0] page_type;
   typedef logic [SLOT_W-1:0]    slot_type;
   typedef logic [RANK_W-1:0]    rank_type;
   typedef logic [COUNT_W-1:0]   count_type;

   // Operation codes; code 3 is unused and does nothing
   typedef enum logic [1:0] {
      MODE_LOOKUP = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_FLUSH  = 2'd2
   } mode_type;

   // Command from the sequencer to the tag array
   typedef struct packed {
      logic       strobe;
      logic [1:0] mode;
      page_type   vpn;
   } tag_cmd_type;

   // Decision of the tag array for the current command
   typedef struct packed {
      logic     lookup_hit;
      logic     ins_write;
      logic     evicted;
      slot_type slot;
      page_type evicted_vpn;
   } tag_res_type;

endpackage

/* rtl/tll_if.sv */
interface tll_req_if
   import tll_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   page_type   vpn;
   page_type   pfn;
   logic       perm_read;
   logic       perm_write;
   logic       perm_exec;

   modport source (output valid, mode, vpn, pfn, perm_read, perm_write, perm_exec,
                   input ready);
   modport sink   (input valid, mode, vpn, pfn, perm_read, perm_write, perm_exec,
                   output ready);
endinterface

interface tll_rsp_if
   import tll_pkg::*;
();
   logic     valid;
   logic     ready;
   logic     hit;
   page_type frame;
   logic     read_ok;
   logic     write_ok;
   logic     exec_ok;
   logic     evicted;
   page_type evicted_vpn;

   modport source (output valid, hit, frame, read_ok, write_ok, exec_ok, evicted,
                   evicted_vpn, input ready);
   modport sink   (input valid, hit, frame, read_ok, write_ok, exec_ok, evicted,
                   evicted_vpn, output ready);
endinterface

/* rtl/tll_ram.sv */
module tll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tll_tag_array.sv */
module tll_tag_array
   import tll_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  tag_cmd_type cmd,
   input  count_type   cap,
   output tag_res_type res
);

   logic [ENTRIES-1:0] valid_ff;
   page_type           tag_ff  [ENTRIES];
   rank_type           rank_ff [ENTRIES];
   count_type          fill_ff;

   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] victim;
   slot_type           hit_slot;
   slot_type           victim_slot;
   slot_type           free_slot;
   rank_type           last_rank;
   rank_type           ref_rank;
   logic               any_hit;
   logic               promote;
   logic               bump_all;

   // Compare all tags in parallel; tags and ranks of valid entries are distinct
   always_comb begin
      match       = '0;
      victim      = '0;
      hit_slot    = '0;
      victim_slot = '0;
      free_slot   = '0;
      last_rank   = rank_type'(fill_ff - 1'b1);
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]  = valid_ff[i] && (tag_ff[i] == cmd.vpn);
         victim[i] = valid_ff[i] && (rank_ff[i] == last_rank);
         if (match[i]) begin
            hit_slot = hit_slot | slot_type'(i);
         end
         if (victim[i]) begin
            victim_slot = victim_slot | slot_type'(i);
         end
      end
      // Lowest free slot
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = slot_type'(i);
         end
      end
   end

   assign any_hit = |match;

   // Pick the slot and the recency update for the command
   always_comb begin
      res      = '0;
      promote  = 1'b0;
      bump_all = 1'b0;
      if (cmd.mode == MODE_LOOKUP) begin
         if (any_hit) begin
            res.lookup_hit = 1'b1;
            res.slot       = hit_slot;
            promote        = 1'b1;
         end
      end else if (cmd.mode == MODE_INSERT) begin
         res.ins_write = 1'b1;
         if (any_hit) begin
            res.slot = hit_slot;
            promote  = 1'b1;
         end else if (fill_ff < cap) begin
            res.slot = free_slot;
            bump_all = 1'b1;
         end else begin
            res.slot        = victim_slot;
            res.evicted     = 1'b1;
            res.evicted_vpn = tag_ff[victim_slot];
            promote         = 1'b1;
         end
      end
   end

   assign ref_rank = rank_ff[res.slot];

   // Valid bits, ranks and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (cmd.strobe) begin
         if (cmd.mode == MODE_FLUSH) begin
            valid_ff <= '0;
            fill_ff  <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
               rank_ff[i] <= '0;
            end
         end else if (promote || bump_all) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && (bump_all || (rank_ff[i] < ref_rank))) begin
                  rank_ff[i] <= rank_ff[i] + 1'b1;
               end
               if (res.slot == slot_type'(i)) begin
                  rank_ff[i]  <= '0;
                  valid_ff[i] <= 1'b1;
               end
            end
            if (bump_all) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
      end
   end

   // Tag store
   always_ff @(posedge clock) begin
      if (cmd.strobe && res.ins_write) begin
         tag_ff[res.slot] <= cmd.vpn;
      end
   end

endmodule

/* rtl/tlb_lru_lookup_unit.sv */
// Fully associative translation buffer with least-recently-used replacement.
//
// req_chan carries one operation per transfer: lookup, insert (or update in
// place) or flush all; code 3 does nothing. rsp_chan returns exactly one
// result per request: hit, frame and stored permissions for a lookup, evicted
// page for an insert that displaced the least recent entry, zeros otherwise.
// csr_we/csr_wdata set the capacity (0 acts as 1, above 16 acts as 16); write
// it only while no request is in flight.
//
// Timing: a request transfer is registered in the idle state, the tags are
// compared in the exec state, and the read state loads the frame/permission
// memory data into the output register; a new request is taken only in idle.
// The request is taken while an earlier result still waits in the output
// register; if rsp_chan stalls, the next result holds in the read stage and
// no further request is taken until the output register frees.
//
// Reset (synchronous, active high) empties the buffer, clears all valid bits
// and ranks and sets the capacity to 16. No clearing pass is needed.
module tlb_lru_lookup_unit
   import tll_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   tll_req_if.sink         req_chan,
   tll_rsp_if.source       rsp_chan,
   input  logic            csr_we,
   input  logic [CAP_W-1:0] csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ
   } state_type;

   state_type          state_ff;
   logic [CAP_W-1:0]   capacity_ff;
   count_type          cap_eff;

   logic [1:0]         req_mode_ff;
   page_type           req_vpn_ff;
   page_type           req_pfn_ff;
   logic [PERM_W-1:0]  req_perm_ff;

   logic               pend_hit_ff;
   logic               pend_evicted_ff;
   page_type           pend_evicted_vpn_ff;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   page_type           rsp_frame_ff;
   logic [PERM_W-1:0]  rsp_perm_ff;
   logic               rsp_evicted_ff;
   page_type           rsp_evicted_vpn_ff;

   tag_cmd_type        tag_cmd;
   tag_res_type        tag_res;
   logic [DATA_W-1:0]  ram_rd_data;
   logic               out_free;

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_W'(CAP_RESET);
      end else if (csr_we) begin
         capacity_ff <= csr_wdata;
      end
   end

   // Clamp capacity to 1..ENTRIES
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = count_type'(1);
      end else if (int'(capacity_ff) > ENTRIES) begin
         cap_eff = count_type'(ENTRIES);
      end else begin
         cap_eff = count_type'(capacity_ff);
      end
   end

   assign tag_cmd.strobe = (state_ff == ST_EXEC);
   assign tag_cmd.mode   = req_mode_ff;
   assign tag_cmd.vpn    = req_vpn_ff;

   tll_tag_array u_tag_array (
      .clock (clock),
      .reset (reset),
      .cmd   (tag_cmd),
      .cap   (cap_eff),
      .res   (tag_res)
   );

   // Frame and permissions, one word per slot
   tll_ram #(
      .WIDTH (DATA_W),
      .DEPTH (ENTRIES)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (tag_cmd.strobe && tag_res.ins_write),
      .wr_addr (tag_res.slot),
      .wr_data ({req_perm_ff, req_pfn_ff}),
      .rd_en   (tag_cmd.strobe && tag_res.lookup_hit),
      .rd_addr (tag_res.slot),
      .rd_data (ram_rd_data)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // Sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the result once it transfers, unless the read stage refills it
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != ST_READ)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  req_mode_ff <= req_chan.mode;
                  req_vpn_ff  <= req_chan.vpn;
                  req_pfn_ff  <= req_chan.pfn;
                  req_perm_ff <= {req_chan.perm_exec, req_chan.perm_write,
                                  req_chan.perm_read};
                  state_ff    <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               pend_hit_ff         <= tag_res.lookup_hit;
               pend_evicted_ff     <= tag_res.evicted;
               pend_evicted_vpn_ff <= tag_res.evicted_vpn;
               state_ff            <= ST_READ;
            end
            ST_READ: begin
               // hold here while the output register is still occupied
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_hit_ff         <= pend_hit_ff;
                  rsp_frame_ff       <= pend_hit_ff ? ram_rd_data[PAGE_BITS-1:0] : '0;
                  rsp_perm_ff        <= pend_hit_ff ? ram_rd_data[DATA_W-1:PAGE_BITS] : '0;
                  rsp_evicted_ff     <= pend_evicted_ff;
                  rsp_evicted_vpn_ff <= pend_evicted_vpn_ff;
                  state_ff           <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.frame       = rsp_frame_ff;
   assign rsp_chan.read_ok     = rsp_perm_ff[0];
   assign rsp_chan.write_ok    = rsp_perm_ff[1];
   assign rsp_chan.exec_ok     = rsp_perm_ff[2];
   assign rsp_chan.evicted     = rsp_evicted_ff;
   assign rsp_chan.evicted_vpn = rsp_evicted_vpn_ff;

endmodule

/* rtl/tll_checker.sv */
module tll_checker
   import tll_pkg::*;
(
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input logic     rsp_hit,
   input page_type rsp_frame,
   input logic     rsp_read_ok,
   input logic     rsp_write_ok,
   input logic     rsp_exec_ok,
   input logic     rsp_evicted,
   input page_type rsp_evicted_vpn
);

   // One request in flight: no second transfer right after one
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken in back-to-back cycles");

   // A stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_frame)
                                     && $stable(rsp_evicted_vpn)))
      else $error("stalled result changed");

   // A miss carries no frame and no permissions
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_frame == '0 && !rsp_read_ok
                                   && !rsp_write_ok && !rsp_exec_ok))
      else $error("miss with nonzero translation");

   // A hit never reports an eviction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_evicted)
      else $error("hit and eviction in one result");

   // Evicted page is zero unless an eviction is reported
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted) |-> (rsp_evicted_vpn == '0))
      else $error("evicted page without eviction");

endmodule

bind tlb_lru_lookup_unit tll_checker u_tll_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_hit         (rsp_chan.hit),
   .rsp_frame       (rsp_chan.frame),
   .rsp_read_ok     (rsp_chan.read_ok),
   .rsp_write_ok    (rsp_chan.write_ok),
   .rsp_exec_ok     (rsp_chan.exec_ok),
   .rsp_evicted     (rsp_chan.evicted),
   .rsp_evicted_vpn (rsp_chan.evicted_vpn)
);

/* bench/tb_tlb_lru_lookup_unit.sv */
module tb_tlb_lru_lookup_unit;
   import tll_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_NOP = 2'd3;
   localparam int PAGE_MAX = (1 << PAGE_BITS) - 1;

   // One translation result as it appears on rsp_chan
   typedef struct packed {
      logic     hit;
      page_type frame;
      logic     read_ok;
      logic     write_ok;
      logic     exec_ok;
      logic     evicted;
      page_type evicted_vpn;
   } tll_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CAP_W-1:0] csr_wdata;

   tll_req_if req_chan ();
   tll_rsp_if rsp_chan ();

   tlb_lru_lookup_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the buffer
   logic           valid_q [ENTRIES];
   page_type       tag_q   [ENTRIES];
   page_type       frame_q [ENTRIES];
   logic [2:0]     perm_q  [ENTRIES];
   rank_type       rank_q  [ENTRIES];
   count_type      fill_q;
   logic [CAP_W-1:0] cap_q;

   tll_result_type pending_results[$];
   int  error_count = 0;
   bit  gaps_on;
   bit  stalls_on;
   int  stall_left = 0;
   page_type page_pool[32];

   always #1 clock = ~clock;

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   function automatic int find_page(input page_type vpn);
      for (int i = 0; i < ENTRIES; i++) begin
         if (valid_q[i] && tag_q[i] == vpn) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Move a valid slot to the front of the recency order
   function automatic void make_recent(input int slot);
      rank_type old_rank;
      old_rank = rank_q[slot];
      for (int i = 0; i < ENTRIES; i++) begin
         if (valid_q[i] && rank_q[i] < old_rank) begin
            rank_q[i]++;
         end
      end
      rank_q[slot] = '0;
   endfunction

   // Apply one operation to the shadow buffer and return its result
   function automatic tll_result_type model_translate(input logic [1:0] mode,
                                                      input page_type vpn,
                                                      input page_type pfn,
                                                      input logic [2:0] perm);
      tll_result_type res;
      int slot;
      int cap;
      rank_type oldest;
      res = '0;
      cap = (cap_q == 0) ? 1 : ((cap_q > ENTRIES) ? ENTRIES : int'(cap_q));
      case (mode)
         MODE_LOOKUP: begin
            slot = find_page(vpn);
            if (slot >= 0) begin
               res.hit = 1'b1;
               res.frame = frame_q[slot];
               {res.exec_ok, res.write_ok, res.read_ok} = perm_q[slot];
               make_recent(slot);
            end
         end
         MODE_INSERT: begin
            slot = find_page(vpn);
            if (slot < 0 && fill_q < cap) begin
               // take the first free slot, age everything else
               for (int i = 0; i < ENTRIES; i++) begin
                  if (slot < 0 && !valid_q[i]) begin
                     slot = i;
                  end
               end
               if (slot >= 0) begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (valid_q[i]) begin
                        rank_q[i]++;
                     end
                  end
                  valid_q[slot] = 1'b1;
                  rank_q[slot] = '0;
                  fill_q++;
               end
            end else if (slot < 0) begin
               // replace the least recent entry
               oldest = '0;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (valid_q[i] && (slot < 0 || rank_q[i] > oldest)) begin
                     slot = i;
                     oldest = rank_q[i];
                  end
               end
               if (slot >= 0) begin
                  res.evicted = 1'b1;
                  res.evicted_vpn = tag_q[slot];
                  make_recent(slot);
               end
            end else begin
               make_recent(slot);
            end
            if (slot >= 0) begin
               tag_q[slot] = vpn;
               frame_q[slot] = pfn;
               perm_q[slot] = perm;
            end
         end
         MODE_FLUSH: begin
            for (int i = 0; i < ENTRIES; i++) begin
               valid_q[i] = 1'b0;
               rank_q[i] = '0;
            end
            fill_q = '0;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Track register writes and request transfers, check each result transfer
   always @(posedge clock) begin : track_and_check
      tll_result_type got;
      tll_result_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            valid_q[i] = 1'b0;
            rank_q[i] = '0;
            tag_q[i] = '0;
            frame_q[i] = '0;
            perm_q[i] = '0;
         end
         fill_q = '0;
         cap_q = CAP_W'(CAP_RESET);
      end else begin
         if (csr_we) begin
            cap_q = csr_wdata;
         end
         if (req_chan.valid && req_chan.ready) begin
            pending_results.push_back(model_translate(req_chan.mode, req_chan.vpn,
               req_chan.pfn, {req_chan.perm_exec, req_chan.perm_write, req_chan.perm_read}));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.hit, rsp_chan.frame, rsp_chan.read_ok, rsp_chan.write_ok,
                    rsp_chan.exec_ok, rsp_chan.evicted, rsp_chan.evicted_vpn};
            if (pending_results.size() == 0) begin
               report_error($sformatf("unexpected result at %0t", $time));
            end else begin
               want = pending_results.pop_front();
               if (got.hit !== want.hit || got.frame !== want.frame ||
                   got.read_ok !== want.read_ok || got.write_ok !== want.write_ok ||
                   got.exec_ok !== want.exec_ok || got.evicted !== want.evicted ||
                   got.evicted_vpn !== want.evicted_vpn) begin
                  report_error($sformatf({"mismatch at %0t: expected hit=%0b frame=%05h ",
                     "rwx=%0b%0b%0b evicted=%0b evicted_vpn=%05h, got hit=%0b frame=%05h ",
                     "rwx=%0b%0b%0b evicted=%0b evicted_vpn=%05h"}, $time,
                     want.hit, want.frame, want.read_ok, want.write_ok, want.exec_ok,
                     want.evicted, want.evicted_vpn, got.hit, got.frame, got.read_ok,
                     got.write_ok, got.exec_ok, got.evicted, got.evicted_vpn));
               end
            end
         end
      end
   end

   // Drive result ready, stalling in short random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready = 1'b0;
         stall_left--;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
         rsp_chan.ready = 1'b0;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_chan.ready = 1'b1;
      end
   end

   // Present one operation and hold it until the transfer
   task automatic send_op(input logic [1:0] mode, input page_type vpn,
                          input page_type pfn, input logic [2:0] perm);
      int gap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         @(negedge clock);
         req_chan.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.mode = mode;
      req_chan.vpn = vpn;
      req_chan.pfn = pfn;
      {req_chan.perm_exec, req_chan.perm_write, req_chan.perm_read} = perm;
      req_chan.valid = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Drop valid and wait until every result has come back
   task automatic settle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      settle();
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Random operations over a small pool of pages so that hits and evictions occur
   task automatic random_ops(input int count, input int pool_n);
      int op;
      page_type vpn;
      logic [1:0] mode;
      for (int i = 0; i < pool_n; i++) begin
         page_pool[i] = page_type'($urandom_range(0, PAGE_MAX));
      end
      for (int n = 0; n < count; n++) begin
         op = $urandom_range(0, 99);
         vpn = page_pool[$urandom_range(0, pool_n - 1)];
         if ($urandom_range(0, 99) < 8) begin
            vpn = page_type'($urandom_range(0, PAGE_MAX));
         end
         if (op < 46) begin
            mode = MODE_LOOKUP;
         end else if (op < 93) begin
            mode = MODE_INSERT;
         end else if (op < 96) begin
            mode = MODE_FLUSH;
         end else begin
            mode = MODE_NOP;
         end
         send_op(mode, vpn, page_type'($urandom_range(0, PAGE_MAX)),
                 3'($urandom_range(0, 7)));
      end
   endtask

   // Lookups, inserts, in-place update, unused code and flush at default capacity
   task automatic test_basic_operations();
      send_op(MODE_LOOKUP, 20'h00000, 20'h00000, 3'b000);
      send_op(MODE_INSERT, 20'h00000, 20'hFFFFF, 3'b111);
      send_op(MODE_INSERT, 20'hFFFFF, 20'h00000, 3'b000);
      send_op(MODE_INSERT, 20'h5A5A5, 20'hA5A5A, 3'b101);
      send_op(MODE_LOOKUP, 20'h00000, 20'hFFFFF, 3'b111);
      send_op(MODE_LOOKUP, 20'hFFFFF, 20'h00000, 3'b000);
      send_op(MODE_INSERT, 20'h00000, 20'h12345, 3'b010);
      send_op(MODE_LOOKUP, 20'h00000, 20'h00000, 3'b000);
      send_op(MODE_NOP,    20'h00000, 20'hFFFFF, 3'b111);
      send_op(MODE_FLUSH,  20'hFFFFF, 20'hFFFFF, 3'b111);
      send_op(MODE_LOOKUP, 20'hFFFFF, 20'h00000, 3'b000);
   endtask

   // Capacity of zero acts as one, then a small capacity with recency order
   task automatic test_capacity_edges();
      write_capacity(5'd0);
      send_op(MODE_INSERT, 20'h00001, 20'h11111, 3'b001);
      send_op(MODE_INSERT, 20'h80000, 20'h22222, 3'b110);
      send_op(MODE_LOOKUP, 20'h00001, 20'h00000, 3'b000);
      send_op(MODE_LOOKUP, 20'h80000, 20'h00000, 3'b000);
      write_capacity(5'd2);
      send_op(MODE_INSERT, 20'h3C3C3, 20'h33333, 3'b011);
      send_op(MODE_LOOKUP, 20'h80000, 20'h00000, 3'b000);
      send_op(MODE_INSERT, 20'hC3C3C, 20'h44444, 3'b100);
   endtask

   // Capacity above the entry count, then lowered below the fill count
   task automatic test_lowered_capacity();
      write_capacity(5'd31);
      send_op(MODE_INSERT, 20'h7FFFE, 20'h55555, 3'b111);
      write_capacity(5'd1);
      send_op(MODE_INSERT, 20'h00FF0, 20'h66666, 3'b010);
      send_op(MODE_INSERT, 20'hFF00F, 20'h77777, 3'b101);
      send_op(MODE_LOOKUP, 20'h7FFFE, 20'h00000, 3'b000);
   endtask

   // Random traffic across several capacities with idling on both sides
   task automatic test_random_mix();
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      write_capacity(5'd16);
      random_ops(70, 28);
      write_capacity(5'd1);
      random_ops(40, 6);
      gaps_on = 1'b0;
      write_capacity(5'd0);
      random_ops(30, 6);
      gaps_on = 1'b1;
      stalls_on = 1'b0;
      write_capacity(5'd31);
      random_ops(80, 32);
      stalls_on = 1'b1;
      write_capacity(CAP_W'($urandom_range(2, 15)));
      random_ops(70, 20);
      write_capacity(5'd17);
      random_ops(40, 24);
   endtask

   // Full-rate traffic with no idling at all
   task automatic test_back_to_back();
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      write_capacity(CAP_W'($urandom_range(1, 16)));
      random_ops(98, 20);
   endtask

   initial begin
      int drain_cycles;
      reset = 1'b1;
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_LOOKUP;
      req_chan.vpn = '0;
      req_chan.pfn = '0;
      req_chan.perm_read = 1'b0;
      req_chan.perm_write = 1'b0;
      req_chan.perm_exec = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_operations();
      test_capacity_edges();
      test_lowered_capacity();
      test_random_mix();
      test_back_to_back();

      // Drain the pipeline, then let it sit a few cycles
      @(negedge clock);
      req_chan.valid = 1'b0;
      drain_cycles = 0;
      while (pending_results.size() != 0 && drain_cycles < 2000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (6) @(posedge clock);
      if (pending_results.size() != 0) begin
         report_error($sformatf("%0d results never arrived", pending_results.size()));
      end
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Hard stop in case the handshake hangs
   initial begin
      #200000;
      $display("Verification failed");
      $finish;
   end

endmodule

/* tlb_lru_lookup_unit.f */
rtl/tll_pkg.sv
rtl/tll_if.sv
rtl/tll_ram.sv
rtl/tll_tag_array.sv
rtl/tlb_lru_lookup_unit.sv
rtl/tll_checker.sv
bench/tb_tlb_lru_lookup_unit.sv
